/* sv/jrq_pkg.sv */
package jrq_pkg;

    localparam int IN_W = 16;
    localparam int Q_W = 34;
    localparam int PROD_W = 2 * Q_W;
    // Axis normalization depth: entry stage, 16 root stages, 16 divide stages.
    localparam int NORM_LAT = 33;

    localparam logic signed [Q_W-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [Q_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [Q_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Q_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef logic signed [Q_W-1:0] q30_t;

    typedef struct packed {
        q30_t x;
        q30_t y;
        q30_t z;
        logic neg;
    } cordic_t;

    function automatic q30_t atan_q30(input int i);
        q30_t r;
        r = '0;
        unique case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default:
            begin
                if (i <= 30)
                    r = q30_t'(64'sd1 <<< (30 - i));
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

    // Round a Q.30 product back to Q.30.
    function automatic q30_t qmul(input q30_t a, input q30_t b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b) + (PROD_W'(1) <<< 29);
        return q30_t'(p >>> 30);
    endfunction

    function automatic cordic_t cordic_init(input logic signed [IN_W-1:0] raw);
        cordic_t c;
        q30_t z;
        z = q30_t'(raw) <<< 16;
        c.x = CORDIC_GAIN_Q30;
        c.y = '0;
        c.neg = 1'b0;
        if (z > HALF_PI_Q30)
        begin
            z = z - PI_Q30;
            c.neg = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z = z + PI_Q30;
            c.neg = 1'b1;
        end
        c.z = z;
        return c;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t c, input int i);
        cordic_t r;
        r = c;
        if (c.z >= 0)
        begin
            r.x = c.x - (c.y >>> i);
            r.y = c.y + (c.x >>> i);
            r.z = c.z - atan_q30(i);
        end
        else
        begin
            r.x = c.x + (c.y >>> i);
            r.y = c.y - (c.x >>> i);
            r.z = c.z + atan_q30(i);
        end
        return r;
    endfunction

endpackage

/* sv/jrq_cordic.sv */
// One CORDIC rotation step per pipeline stage; four angles side by side.
module jrq_cordic
    import jrq_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   vin,
    input  cordic_t [3:0]          cin,
    output logic                   vout,
    output cordic_t [3:0]          cout
);

    cordic_t [3:0] st_reg [STAGES];
    logic [STAGES-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[STAGES-2:0], vin};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                st_reg[0][k] <= cordic_step(cin[k], 0);
                for (int s = 1; s < STAGES; s++)
                    st_reg[s][k] <= cordic_step(st_reg[s-1][k], s);
            end
        end
    end

    assign vout = v_reg[STAGES-1];
    assign cout = st_reg[STAGES-1];

endmodule

/* sv/jrq_norm.sv */
// Axis normalization: bit-serial square root then restoring divides, two bits
// per stage, pipelined. The divisor is s = floor(sqrt(n2 * 2^32)).
module jrq_norm
    import jrq_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] ax,
    input  logic signed [IN_W-1:0] ay,
    input  logic signed [IN_W-1:0] az,
    output q30_t                   ux,
    output q30_t                   uy,
    output q30_t                   uz,
    output logic                   zero_axis
);

    localparam int RW = 32;            // sqrt of 64-bit value
    localparam int NW = 64;
    localparam int QW = 32;            // quotient bits (unit <= 2^30)
    localparam int DW = 63;            // dividend width: m << 46 + s/2
    localparam int SQ_PER = 2;         // sqrt bits per stage
    localparam int SQ_ST = RW / SQ_PER;
    localparam int DV_PER = 2;
    localparam int DV_ST = QW / DV_PER;
    localparam int TOT = SQ_ST + DV_ST + 1;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [RW-1:0] root;
        logic [2:0][15:0] mag;
        logic [2:0] sgn;
        logic [2:0][QW-1:0] q;
        logic [2:0][DW-1:0] dr;
        logic zero;
    } nstate_t;

    nstate_t p_reg [TOT];
    nstate_t n0;

    function automatic logic [15:0] absv(input logic signed [IN_W-1:0] a);
        return a[IN_W-1] ? 16'(-a) : 16'(a);
    endfunction

    always_comb
    begin
        logic [33:0] n2;
        n2 = 34'(absv(ax)) * 34'(absv(ax)) + 34'(absv(ay)) * 34'(absv(ay))
           + 34'(absv(az)) * 34'(absv(az));
        n0 = '0;
        n0.rem = {n2[31:0], 32'd0};
        n0.mag = {absv(az), absv(ay), absv(ax)};
        n0.sgn = {az[IN_W-1], ay[IN_W-1], ax[IN_W-1]};
        n0.zero = (n2 == '0);
    end

    function automatic nstate_t sq_step(input nstate_t a, input int st);
        nstate_t r;
        logic [NW-1:0] trial;
        int b;
        r = a;
        for (int j = 0; j < SQ_PER; j++)
        begin
            b = RW - 1 - (st * SQ_PER + j);
            trial = (NW'(r.root) << (b + 1)) + (NW'(1) << (2 * b));
            if (r.rem >= trial)
            begin
                r.rem = r.rem - trial;
                r.root[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic nstate_t dv_init(input nstate_t a);
        nstate_t r;
        r = a;
        for (int k = 0; k < 3; k++)
        begin
            r.dr[k] = (DW'(a.mag[k]) << 46) + DW'(a.root >> 1);
            r.q[k] = '0;
        end
        return r;
    endfunction

    function automatic nstate_t dv_step(input nstate_t a, input int st);
        nstate_t r;
        logic [DW+QW-1:0] d;
        int b;
        r = a;
        for (int j = 0; j < DV_PER; j++)
        begin
            b = QW - 1 - (st * DV_PER + j);
            for (int k = 0; k < 3; k++)
            begin
                d = (DW+QW)'(r.root) << b;
                if ((DW+QW)'(r.dr[k]) >= d && r.root != '0)
                begin
                    r.dr[k] = DW'((DW+QW)'(r.dr[k]) - d);
                    r.q[k][b] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= n0;
            for (int s = 1; s <= SQ_ST; s++)
                p_reg[s] <= sq_step(p_reg[s-1], s - 1);
            p_reg[SQ_ST+1] <= dv_step(dv_init(p_reg[SQ_ST]), 0);
            for (int s = SQ_ST + 2; s < TOT; s++)
                p_reg[s] <= dv_step(p_reg[s-1], s - SQ_ST - 1);
        end
    end

    nstate_t fin;

    assign fin = p_reg[TOT-1];

    assign ux = fin.sgn[0] ? -q30_t'(fin.q[0]) : q30_t'(fin.q[0]);
    assign uy = fin.sgn[1] ? -q30_t'(fin.q[1]) : q30_t'(fin.q[1]);
    assign uz = fin.sgn[2] ? -q30_t'(fin.q[2]) : q30_t'(fin.q[2]);
    assign zero_axis = fin.zero;

endmodule

/* sv/jrq_combine.sv */
// Quaternion assembly: half-angle products, joint quaternion, Hamilton
// product and output rounding, one multiplier layer per stage.
module jrq_combine
    import jrq_pkg::*;
#(
    parameter int FRAC = 14
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  cordic_t [3:0] cin,
    input  q30_t          ux,
    input  q30_t          uy,
    input  q30_t          uz,
    input  logic          zero_axis,
    output logic          vout,
    output logic [IN_W-1:0] qx,
    output logic [IN_W-1:0] qy,
    output logic [IN_W-1:0] qz,
    output logic [IN_W-1:0] qw
);

    localparam int SH = 30 - FRAC;

    logic [3:0] v_reg;
    q30_t sr, cr, sp, cp, sy, cy, sj, cj;

    // stage 1
    q30_t scp_reg, csp_reg, ccp_reg, ssp_reg, sy1_reg, cy1_reg;
    q30_t sj1_reg, cj1_reg, ux1_reg, uy1_reg, uz1_reg;
    logic zero1_reg;
    // stage 2
    q30_t ox_reg, oy_reg, oz_reg, ow_reg, jx_reg, jy_reg, jz_reg, jw_reg;
    // stage 3
    q30_t rx_reg, ry_reg, rz_reg, rw_reg;

    function automatic q30_t sgnf(input q30_t v, input logic n);
        return n ? -v : v;
    endfunction

    function automatic logic [IN_W-1:0] to_out(input q30_t v);
        logic signed [Q_W:0] t;
        logic signed [Q_W:0] lim;
        lim = (Q_W+1)'(1) <<< FRAC;
        t = ((Q_W+1)'(v) + ((Q_W+1)'(1) <<< (SH - 1))) >>> SH;
        if (t > lim)
            t = lim;
        if (t < -lim)
            t = -lim;
        return t[IN_W-1:0];
    endfunction

    assign sr = sgnf(cin[0].y, cin[0].neg);
    assign cr = sgnf(cin[0].x, cin[0].neg);
    assign sp = sgnf(cin[1].y, cin[1].neg);
    assign cp = sgnf(cin[1].x, cin[1].neg);
    assign sy = sgnf(cin[2].y, cin[2].neg);
    assign cy = sgnf(cin[2].x, cin[2].neg);
    assign sj = sgnf(cin[3].y, cin[3].neg);
    assign cj = sgnf(cin[3].x, cin[3].neg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], vin};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scp_reg <= qmul(sr, cp);
            csp_reg <= qmul(cr, sp);
            ccp_reg <= qmul(cr, cp);
            ssp_reg <= qmul(sr, sp);
            sy1_reg <= sy;
            cy1_reg <= cy;
            sj1_reg <= sj;
            cj1_reg <= cj;
            ux1_reg <= ux;
            uy1_reg <= uy;
            uz1_reg <= uz;
            zero1_reg <= zero_axis;

            ox_reg <= qmul(scp_reg, cy1_reg) - qmul(csp_reg, sy1_reg);
            oy_reg <= qmul(csp_reg, cy1_reg) + qmul(scp_reg, sy1_reg);
            oz_reg <= qmul(ccp_reg, sy1_reg) - qmul(ssp_reg, cy1_reg);
            ow_reg <= qmul(ccp_reg, cy1_reg) + qmul(ssp_reg, sy1_reg);
            jx_reg <= zero1_reg ? '0 : qmul(ux1_reg, sj1_reg);
            jy_reg <= zero1_reg ? '0 : qmul(uy1_reg, sj1_reg);
            jz_reg <= zero1_reg ? '0 : qmul(uz1_reg, sj1_reg);
            jw_reg <= zero1_reg ? ONE_Q30 : cj1_reg;

            rx_reg <= qmul(ow_reg, jx_reg) + qmul(ox_reg, jw_reg)
                    + qmul(oy_reg, jz_reg) - qmul(oz_reg, jy_reg);
            ry_reg <= qmul(ow_reg, jy_reg) - qmul(ox_reg, jz_reg)
                    + qmul(oy_reg, jw_reg) + qmul(oz_reg, jx_reg);
            rz_reg <= qmul(ow_reg, jz_reg) + qmul(ox_reg, jy_reg)
                    - qmul(oy_reg, jx_reg) + qmul(oz_reg, jw_reg);
            rw_reg <= qmul(ow_reg, jw_reg) - qmul(ox_reg, jx_reg)
                    - qmul(oy_reg, jy_reg) - qmul(oz_reg, jz_reg);

            qx <= to_out(rx_reg);
            qy <= to_out(ry_reg);
            qz <= to_out(rz_reg);
            qw <= to_out(rw_reg);
        end
    end

    assign vout = v_reg[3];

endmodule

/* sv/joint_rotation_quaternion_top.sv */
// Depth: 37 register stages from an input transaction to its result, for any
// TRIG_STAGES up to 32.
// Throughput: one transaction per cycle; the whole pipe advances when the
// output register is empty or being taken, and holds otherwise.
// The axis normalization (33 stages) sets the depth; angles wait in a delay
// line so the CORDIC pipe finishes with it. Reset clears only the valid bits.
module joint_rotation_quaternion_top
    import jrq_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int TRIG_STAGES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [IN_W-1:0] origin_roll,
    input  logic signed [IN_W-1:0] origin_pitch,
    input  logic signed [IN_W-1:0] origin_yaw,
    input  logic signed [IN_W-1:0] axis_x,
    input  logic signed [IN_W-1:0] axis_y,
    input  logic signed [IN_W-1:0] axis_z,
    input  logic signed [IN_W-1:0] joint_angle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [IN_W-1:0] quat_x,
    output logic signed [IN_W-1:0] quat_y,
    output logic signed [IN_W-1:0] quat_z,
    output logic signed [IN_W-1:0] quat_w
);

    localparam int ANG_PAD = NORM_LAT - TRIG_STAGES;

    logic en;
    cordic_t [3:0] c_in, c_out;
    logic c_v;
    q30_t ux, uy, uz;
    logic zero_axis;
    logic [IN_W-1:0] qx, qy, qz, qw;
    logic [3:0][IN_W-1:0] ang_reg [ANG_PAD];
    logic [ANG_PAD-1:0] vpad_reg;

    // Advance whenever the last stage is empty or draining.
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // Hold the angles back until the axis normalization catches up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpad_reg <= '0;
        else if (en)
        begin
            vpad_reg[0] <= in_valid;
            for (int s = 1; s < ANG_PAD; s++)
                vpad_reg[s] <= vpad_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[0] <= {joint_angle, origin_yaw, origin_pitch, origin_roll};
            for (int s = 1; s < ANG_PAD; s++)
                ang_reg[s] <= ang_reg[s-1];
        end
    end

    assign c_in[0] = cordic_init(ang_reg[ANG_PAD-1][0]);
    assign c_in[1] = cordic_init(ang_reg[ANG_PAD-1][1]);
    assign c_in[2] = cordic_init(ang_reg[ANG_PAD-1][2]);
    assign c_in[3] = cordic_init(ang_reg[ANG_PAD-1][3]);

    jrq_cordic #(.STAGES(TRIG_STAGES)) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (vpad_reg[ANG_PAD-1]),
        .cin  (c_in),
        .vout (c_v),
        .cout (c_out)
    );

    jrq_norm u_norm (
        .clk      (clk),
        .en       (en),
        .ax       (axis_x),
        .ay       (axis_y),
        .az       (axis_z),
        .ux       (ux),
        .uy       (uy),
        .uz       (uz),
        .zero_axis(zero_axis)
    );

    jrq_combine #(.FRAC(QUAT_FRAC_BITS)) u_comb (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (c_v),
        .cin      (c_out),
        .ux       (ux),
        .uy       (uy),
        .uz       (uz),
        .zero_axis(zero_axis),
        .vout     (out_valid),
        .qx       (qx),
        .qy       (qy),
        .qz       (qz),
        .qw       (qw)
    );

    assign quat_x = qx;
    assign quat_y = qy;
    assign quat_z = qz;
    assign quat_w = qw;

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("pipe advanced during output stall");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
        else $error("quat_w outside saturation range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_x))
        else $error("result dropped while stalled");

endmodule
